// ===== hdl/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the boot memory map scanner
// Transfer payloads, walker phases, status codes and tag/entry constants.
// ----------------------------------------------------------------------------
package bmm_pkg;

    typedef struct packed {
        logic [31:0] info_word;
        logic        start_of_info;
    } bmm_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] base_addr;
        logic [63:0] limit_addr;
        logic [44:0] region_mib;
    } bmm_out_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_TAG_TYPE,
        PH_TAG_SIZE,
        PH_MAP_ESIZE,
        PH_MAP_VER,
        PH_ENTRY,
        PH_DONE
    } phase_t;

    // Per-word control from the walker to the region tracker
    typedef struct packed {
        logic clear_best;
        logic base_lo;
        logic base_hi;
        logic len_lo;
        logic len_hi;
        logic kind;
    } bmm_ev_t;

    typedef struct packed {
        logic       valid;
        logic       from_map;
        logic [2:0] status;
    } bmm_fin_t;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NO_MAP    = 3'd1;
    localparam logic [2:0] ST_BAD_INFO  = 3'd2;
    localparam logic [2:0] ST_BAD_MAP   = 3'd3;
    localparam logic [2:0] ST_NO_REGION = 3'd4;

    localparam logic [31:0] TAG_TYPE_END    = 32'd0;
    localparam logic [31:0] TAG_TYPE_MMAP   = 32'd6;
    localparam logic [31:0] ENTRY_TYPE_RAM  = 32'd1;
    localparam logic [31:0] TAG_HDR_BYTES   = 32'd8;
    localparam logic [31:0] INFO_MIN_BYTES  = 32'd16;
    localparam logic [31:0] MAP_MIN_BYTES   = 32'd16;
    localparam logic [31:0] ENTRY_MIN_BYTES = 32'd24;
    localparam logic [31:0] MIN_START_RESET = 32'h0010_0000;

    localparam logic [29:0] IDX_BASE_LO = 30'd0;
    localparam logic [29:0] IDX_BASE_HI = 30'd1;
    localparam logic [29:0] IDX_LEN_LO  = 30'd2;
    localparam logic [29:0] IDX_LEN_HI  = 30'd3;
    localparam logic [29:0] IDX_KIND    = 30'd4;

endpackage

// ===== hdl/bmm_walker.sv =====
// ----------------------------------------------------------------------------
// bmm_walker: boot information tag walker
// Tracks byte position, walks tags to the memory map tag and steps through
// its entries; flags entry words and the final outcome for each word.
// ----------------------------------------------------------------------------
module bmm_walker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  bmm_pkg::bmm_in_t in_item,
    output bmm_pkg::bmm_ev_t ev,
    output bmm_pkg::bmm_fin_t fin
);

    bmm_pkg::phase_t phase_reg, phase_next;
    logic [32:0] end_off_reg, end_off_next;
    logic [31:0] info_size_reg, info_size_next;
    logic [31:0] info_m8_reg, info_m8_next;
    logic [31:0] skip_until_reg, skip_until_next;
    logic [31:0] map_end_reg, map_end_next;
    logic [31:0] tag_pos_reg, tag_pos_next;
    logic [29:0] stride_words_reg, stride_words_next;
    logic [29:0] idx_reg, idx_next;
    logic        tag_end_reg, tag_end_next;
    logic        tag_mmap_reg, tag_mmap_next;

    logic [31:0] w;
    logic        start;
    logic        step;
    logic [32:0] tag_sum;
    logic [29:0] round8;
    logic [33:0] next_pos;
    logic [33:0] map_reach;
    logic [30:0] idx_inc;
    logic        skip_done;
    logic        tag_over;
    logic        next_over;
    logic        next_here;
    logic        map_over;
    logic        last_word;
    logic        end_tag;

    assign w     = in_item.info_word;
    assign start = in_item.start_of_info;
    assign step  = en && in_valid;

    assign skip_done = end_off_reg >= {1'b0, skip_until_reg};
    assign tag_sum   = {1'b0, tag_pos_reg} + {1'b0, w};
    assign tag_over  = tag_sum > {1'b0, info_size_reg};
    assign round8    = {1'b0, w[31:3]} + {29'd0, (w[2:0] != 3'd0)};
    assign next_pos  = {2'b00, tag_pos_reg} + {1'b0, round8, 3'b000};
    assign next_over = next_pos > {2'b00, info_m8_reg};
    assign next_here = next_pos == {1'b0, end_off_reg};
    assign map_reach = {1'b0, end_off_reg} + {2'b00, stride_words_reg, 2'b00};
    assign map_over  = map_reach > {2'b00, map_end_reg};
    assign idx_inc   = {1'b0, idx_reg} + 31'd1;
    assign last_word = idx_inc >= {1'b0, stride_words_reg};
    assign end_tag   = tag_end_reg && (w == bmm_pkg::TAG_HDR_BYTES);

    always_comb begin
        phase_next        = phase_reg;
        end_off_next      = end_off_reg;
        info_size_next    = info_size_reg;
        info_m8_next      = info_m8_reg;
        skip_until_next   = skip_until_reg;
        map_end_next      = map_end_reg;
        tag_pos_next      = tag_pos_reg;
        stride_words_next = stride_words_reg;
        idx_next          = idx_reg;
        tag_end_next      = tag_end_reg;
        tag_mmap_next     = tag_mmap_reg;
        if (start) begin
            info_size_next = w;
            info_m8_next   = w - bmm_pkg::TAG_HDR_BYTES;
            if (w < bmm_pkg::INFO_MIN_BYTES) begin
                phase_next = bmm_pkg::PH_DONE;
            end else begin
                phase_next      = bmm_pkg::PH_SKIP;
                skip_until_next = bmm_pkg::TAG_HDR_BYTES;
                end_off_next    = {1'b0, bmm_pkg::TAG_HDR_BYTES};
            end
        end else if (phase_reg != bmm_pkg::PH_IDLE && phase_reg != bmm_pkg::PH_DONE) begin
            end_off_next = {1'b0, end_off_reg[31:0]} + 33'd4;
            case (phase_reg)
                bmm_pkg::PH_SKIP: begin
                    if (skip_done) begin
                        phase_next   = bmm_pkg::PH_TAG_TYPE;
                        tag_pos_next = end_off_reg[31:0];
                    end
                end
                bmm_pkg::PH_TAG_TYPE: begin
                    tag_end_next  = (w == bmm_pkg::TAG_TYPE_END);
                    tag_mmap_next = (w == bmm_pkg::TAG_TYPE_MMAP);
                    phase_next    = bmm_pkg::PH_TAG_SIZE;
                end
                bmm_pkg::PH_TAG_SIZE: begin
                    if (end_tag || w < bmm_pkg::TAG_HDR_BYTES || tag_over) begin
                        phase_next = bmm_pkg::PH_DONE;
                    end else if (tag_mmap_reg) begin
                        if (w < bmm_pkg::MAP_MIN_BYTES) begin
                            phase_next = bmm_pkg::PH_DONE;
                        end else begin
                            map_end_next = tag_sum[31:0];
                            phase_next   = bmm_pkg::PH_MAP_ESIZE;
                        end
                    end else if (next_over) begin
                        phase_next = bmm_pkg::PH_DONE;
                    end else begin
                        skip_until_next = next_pos[31:0];
                        if (next_here) begin
                            phase_next   = bmm_pkg::PH_TAG_TYPE;
                            tag_pos_next = end_off_reg[31:0];
                        end else begin
                            phase_next = bmm_pkg::PH_SKIP;
                        end
                    end
                end
                bmm_pkg::PH_MAP_ESIZE: begin
                    if (w < bmm_pkg::ENTRY_MIN_BYTES) begin
                        phase_next = bmm_pkg::PH_DONE;
                    end else begin
                        stride_words_next = w[31:2];
                        phase_next        = bmm_pkg::PH_MAP_VER;
                    end
                end
                bmm_pkg::PH_MAP_VER: begin
                    if (map_over) begin
                        phase_next = bmm_pkg::PH_DONE;
                    end else begin
                        idx_next   = '0;
                        phase_next = bmm_pkg::PH_ENTRY;
                    end
                end
                bmm_pkg::PH_ENTRY: begin
                    if (last_word) begin
                        if (map_over) begin
                            phase_next = bmm_pkg::PH_DONE;
                        end else begin
                            idx_next = '0;
                        end
                    end else begin
                        idx_next = idx_inc[29:0];
                    end
                end
                default: begin
                    phase_next = bmm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        ev  = '0;
        fin = '0;
        if (in_valid) begin
            if (start) begin
                ev.clear_best = 1'b1;
                if (w < bmm_pkg::INFO_MIN_BYTES) begin
                    fin.valid  = 1'b1;
                    fin.status = bmm_pkg::ST_BAD_INFO;
                end
            end else begin
                case (phase_reg)
                    bmm_pkg::PH_TAG_SIZE: begin
                        if (end_tag) begin
                            fin.valid  = 1'b1;
                            fin.status = bmm_pkg::ST_NO_MAP;
                        end else if (w < bmm_pkg::TAG_HDR_BYTES || tag_over) begin
                            fin.valid  = 1'b1;
                            fin.status = bmm_pkg::ST_BAD_INFO;
                        end else if (tag_mmap_reg) begin
                            if (w < bmm_pkg::MAP_MIN_BYTES) begin
                                fin.valid  = 1'b1;
                                fin.status = bmm_pkg::ST_BAD_MAP;
                            end else begin
                                ev.clear_best = 1'b1;
                            end
                        end else if (next_over) begin
                            fin.valid  = 1'b1;
                            fin.status = bmm_pkg::ST_NO_MAP;
                        end
                    end
                    bmm_pkg::PH_MAP_ESIZE: begin
                        if (w < bmm_pkg::ENTRY_MIN_BYTES) begin
                            fin.valid  = 1'b1;
                            fin.status = bmm_pkg::ST_BAD_MAP;
                        end
                    end
                    bmm_pkg::PH_MAP_VER: begin
                        if (map_over) begin
                            fin.valid    = 1'b1;
                            fin.from_map = 1'b1;
                        end
                    end
                    bmm_pkg::PH_ENTRY: begin
                        case (idx_reg)
                            bmm_pkg::IDX_BASE_LO: ev.base_lo = 1'b1;
                            bmm_pkg::IDX_BASE_HI: ev.base_hi = 1'b1;
                            bmm_pkg::IDX_LEN_LO:  ev.len_lo  = 1'b1;
                            bmm_pkg::IDX_LEN_HI:  ev.len_hi  = 1'b1;
                            bmm_pkg::IDX_KIND:    ev.kind    = 1'b1;
                            default: ;
                        endcase
                        if (last_word && map_over) begin
                            fin.valid    = 1'b1;
                            fin.from_map = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= bmm_pkg::PH_IDLE;
            end_off_reg      <= '0;
            info_size_reg    <= '0;
            info_m8_reg      <= '0;
            skip_until_reg   <= '0;
            map_end_reg      <= '0;
            tag_pos_reg      <= '0;
            stride_words_reg <= '0;
            idx_reg          <= '0;
            tag_end_reg      <= 1'b0;
            tag_mmap_reg     <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            end_off_reg      <= end_off_next;
            info_size_reg    <= info_size_next;
            info_m8_reg      <= info_m8_next;
            skip_until_reg   <= skip_until_next;
            map_end_reg      <= map_end_next;
            tag_pos_reg      <= tag_pos_next;
            stride_words_reg <= stride_words_next;
            idx_reg          <= idx_next;
            tag_end_reg      <= tag_end_next;
            tag_mmap_reg     <= tag_mmap_next;
        end
    end

endmodule

// ===== hdl/bmm_tracker.sv =====
// ----------------------------------------------------------------------------
// bmm_tracker: memory map entry evaluation and best region tracking
// Builds each entry's end and clamped start, keeps the largest usable
// region and forms the result in the output register.
// ----------------------------------------------------------------------------
module bmm_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [31:0]       in_word,
    input  bmm_pkg::bmm_ev_t  ev,
    input  bmm_pkg::bmm_fin_t fin,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    output logic              m_valid,
    output bmm_pkg::bmm_out_t m_data
);

    logic [31:0]       min_start_reg;
    logic [63:0]       base_reg;
    logic [31:0]       len_lo_reg;
    logic [63:0]       end_reg;
    logic [63:0]       clamp_reg;
    logic              end_ok_reg;
    logic              cand_valid_reg;
    logic [63:0]       cand_bytes_reg;
    logic [63:0]       best_start_reg;
    logic [63:0]       best_end_reg;
    logic [63:0]       best_bytes_reg;
    bmm_pkg::bmm_fin_t fin_reg;
    logic              m_valid_reg;
    bmm_pkg::bmm_out_t m_data_reg;
    bmm_pkg::bmm_out_t m_data_next;

    logic [63:0] len_full;
    logic [64:0] end_sum;
    logic        end_ok_next;
    logic [63:0] clamp_next;
    logic [64:0] diff;
    logic        cand_ok;
    logic        best_take;
    logic        found;
    logic [44:0] mib;

    assign len_full    = {in_word, len_lo_reg};
    assign end_sum     = {1'b0, base_reg} + {1'b0, len_full};
    assign end_ok_next = !end_sum[64] && (end_sum[63:0] != '1) && (len_full != 64'd0);
    assign clamp_next  = (base_reg[63:32] == 32'd0 && base_reg[31:0] < min_start_reg)
                         ? {32'd0, min_start_reg} : base_reg;
    assign diff        = {1'b0, end_reg} - {1'b0, clamp_reg};
    assign cand_ok     = (in_word == bmm_pkg::ENTRY_TYPE_RAM) && end_ok_reg && !diff[64]
                         && (diff[63:0] != 64'd0);
    assign best_take   = cand_valid_reg && (cand_bytes_reg > best_bytes_reg);
    assign found       = best_bytes_reg != 64'd0;
    assign mib         = {1'b0, best_bytes_reg[63:20]} + {44'd0, |best_bytes_reg[19:0]};

    always_comb begin
        m_data_next = '0;
        if (fin_reg.from_map) begin
            m_data_next.status = found ? bmm_pkg::ST_FOUND : bmm_pkg::ST_NO_REGION;
        end else begin
            m_data_next.status = fin_reg.status;
        end
        if (m_data_next.status == bmm_pkg::ST_FOUND) begin
            m_data_next.base_addr  = best_start_reg;
            m_data_next.limit_addr = best_end_reg;
            m_data_next.region_mib = mib;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_start_reg <= bmm_pkg::MIN_START_RESET;
        end else if (cfg_wr_en) begin
            min_start_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_valid_reg <= 1'b0;
            best_bytes_reg <= '0;
            fin_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else if (en) begin
            cand_valid_reg <= ev.kind && cand_ok;
            if (ev.clear_best) begin
                best_bytes_reg <= '0;
            end else if (best_take) begin
                best_bytes_reg <= cand_bytes_reg;
            end
            fin_reg     <= fin;
            m_valid_reg <= fin_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ev.base_lo) begin
                base_reg[31:0] <= in_word;
            end
            if (ev.base_hi) begin
                base_reg[63:32] <= in_word;
            end
            if (ev.len_lo) begin
                len_lo_reg <= in_word;
            end
            if (ev.len_hi) begin
                end_reg    <= end_sum[63:0];
                end_ok_reg <= end_ok_next;
                clamp_reg  <= clamp_next;
            end
            if (ev.kind) begin
                cand_bytes_reg <= diff[63:0];
            end
            if (ev.clear_best) begin
                best_start_reg <= '0;
                best_end_reg   <= '0;
            end else if (best_take) begin
                best_start_reg <= clamp_reg;
                best_end_reg   <= end_reg;
            end
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/boot_memory_map_best_region.sv =====
// ----------------------------------------------------------------------------
// boot_memory_map_best_region: largest usable region from a boot info block
// Throughput: one word per cycle, sustained while m_ready is high.
// The word that settles a result passes through the input, outcome and result
//   registers, each held while the output stalls, before the result leaves.
// A one-entry skid takes a word while a finished result waits on m_ready.
// Reset clears control state and sets min_start to 0x100000.
// ----------------------------------------------------------------------------
module boot_memory_map_best_region (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmm_pkg::bmm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bmm_pkg::bmm_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data
);

    logic              skid_valid_reg;
    bmm_pkg::bmm_in_t  skid_data_reg;
    logic              in_valid_reg;
    bmm_pkg::bmm_in_t  in_data_reg;
    logic              en;
    logic              accept;
    bmm_pkg::bmm_ev_t  ev;
    bmm_pkg::bmm_fin_t fin;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign en      = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
        end else if (en) begin
            in_valid_reg   <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_data_reg <= skid_valid_reg ? skid_data_reg : s_data;
        end else if (accept) begin
            skid_data_reg <= s_data;
        end
    end

    bmm_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid_reg),
        .in_item  (in_data_reg),
        .ev       (ev),
        .fin      (fin)
    );

    bmm_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_word     (in_data_reg.info_word),
        .ev          (ev),
        .fin         (fin),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: boot memory map scanner, largest usable region
// Streams boot information blocks word by word through the valid/ready input,
// predicts each region report with a cycle-free model of the tag walk and
// entry scan, and checks every report field by field. A short table covers
// the edge cases first, then random blocks run under several floor settings
// and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bmm_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_WORDS = 900;
    localparam int          WORDS_PER_PHASE = 110;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [63:0] ADDR_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] word;
        logic        sof;
        logic        typed;
        logic [2:0]  status;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    bmm_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    bmm_out_t    m_data;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // scanner state mirror
    logic [31:0] floor_addr = MIN_START_RESET;
    phase_t      walk_ph = PH_IDLE;
    logic [31:0] byte_off = '0;
    logic [31:0] info_sz = '0;
    logic [31:0] skip_to = '0;
    logic [31:0] map_end = '0;
    logic [31:0] stride = '0;
    logic [29:0] widx = '0;
    logic [63:0] ent_base = '0;
    logic [63:0] ent_len = '0;
    logic [31:0] ent_kind = '0;
    logic [63:0] best_start = '0;
    logic [63:0] best_end = '0;
    logic [63:0] best_bytes = '0;

    bmm_out_t    pending_reports[$];
    stim_row_t   stim_rows[$];
    logic [31:0] blk[$];
    bmm_out_t    want;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int reports = 0;
    int walked = 0;
    int blocks_started = 0;

    boot_memory_map_best_region dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycles,
                     pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: status %0d start %h end %h mib %0d",
                             m_data.status, m_data.base_addr, m_data.limit_addr,
                             m_data.region_mib);
            end else begin
                want = pending_reports.pop_front();
                if (m_data.status !== want.status ||
                    m_data.base_addr !== want.base_addr ||
                    m_data.limit_addr !== want.limit_addr ||
                    m_data.region_mib !== want.region_mib) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "report %0d exp/act: st %0d/%0d start %h/%h end %h/%h mib %0d/%0d",
                            reports,
                            want.status, m_data.status,
                            want.base_addr, m_data.base_addr,
                            want.limit_addr, m_data.limit_addr,
                            want.region_mib, m_data.region_mib);
                end
            end
        end
    end

    function automatic bmm_out_t status_only(input logic [2:0] st);
        bmm_out_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void weigh_entry();
        logic [64:0] sum;
        logic [63:0] t;
        logic [63:0] s;
        sum = {1'b0, ent_base} + {1'b0, ent_len};
        t = sum[64] ? ADDR_TOP : sum[63:0];
        s = (ent_base < {32'd0, floor_addr}) ? {32'd0, floor_addr} : ent_base;
        if (ent_kind == ENTRY_TYPE_RAM && t != ADDR_TOP && t > ent_base && t > s &&
            t - s > best_bytes) begin
            best_bytes = t - s;
            best_start = s;
            best_end = t;
        end
    endfunction

    task automatic scan_word(input logic [31:0] w, input logic sof,
                             output logic got, output bmm_out_t res);
        logic [63:0] off;
        logic [63:0] p;
        logic [63:0] nxt;
        logic [2:0]  code;
        logic        done;
        got = 1'b0;
        res = '0;
        done = 1'b0;
        code = ST_FOUND;
        if (sof) begin
            info_sz = w;
            best_start = '0;
            best_end = '0;
            best_bytes = '0;
            byte_off = 32'd4;
            skip_to = TAG_HDR_BYTES;
            walk_ph = PH_SKIP;
            if (w < INFO_MIN_BYTES) begin
                done = 1'b1;
                code = ST_BAD_INFO;
            end
        end else if (walk_ph != PH_IDLE && walk_ph != PH_DONE) begin
            off = {32'd0, byte_off};
            case (walk_ph)
                PH_SKIP: begin
                    if (off + 64'd4 >= {32'd0, skip_to})
                        walk_ph = PH_TAG_TYPE;
                end
                PH_TAG_TYPE: begin
                    ent_kind = w;
                    walk_ph = PH_TAG_SIZE;
                end
                PH_TAG_SIZE: begin
                    p = off - 64'd4;
                    nxt = p + (({32'd0, w} + 64'd7) & ~64'd7);
                    if (ent_kind == TAG_TYPE_END && w == TAG_HDR_BYTES) begin
                        done = 1'b1;
                        code = ST_NO_MAP;
                    end else if (w < TAG_HDR_BYTES || p + w > {32'd0, info_sz}) begin
                        done = 1'b1;
                        code = ST_BAD_INFO;
                    end else if (ent_kind == TAG_TYPE_MMAP) begin
                        if (w < MAP_MIN_BYTES) begin
                            done = 1'b1;
                            code = ST_BAD_MAP;
                        end else begin
                            map_end = p[31:0] + w;
                            best_start = '0;
                            best_end = '0;
                            best_bytes = '0;
                            walk_ph = PH_MAP_ESIZE;
                        end
                    end else if (nxt + 64'd8 > {32'd0, info_sz}) begin
                        done = 1'b1;
                        code = ST_NO_MAP;
                    end else begin
                        skip_to = nxt[31:0];
                        walk_ph = (nxt == off + 64'd4) ? PH_TAG_TYPE : PH_SKIP;
                    end
                end
                PH_MAP_ESIZE: begin
                    if (w < ENTRY_MIN_BYTES) begin
                        done = 1'b1;
                        code = ST_BAD_MAP;
                    end else begin
                        stride = w & ~32'd3;
                        walk_ph = PH_MAP_VER;
                    end
                end
                PH_MAP_VER: begin
                    if (off + 64'd4 + stride > {32'd0, map_end}) begin
                        done = 1'b1;
                        code = (best_bytes != 0) ? ST_FOUND : ST_NO_REGION;
                    end else begin
                        widx = '0;
                        walk_ph = PH_ENTRY;
                    end
                end
                PH_ENTRY: begin
                    case (widx)
                        IDX_BASE_LO: ent_base[31:0] = w;
                        IDX_BASE_HI: ent_base[63:32] = w;
                        IDX_LEN_LO:  ent_len[31:0] = w;
                        IDX_LEN_HI:  ent_len[63:32] = w;
                        IDX_KIND: begin
                            ent_kind = w;
                            weigh_entry();
                        end
                        default: ;
                    endcase
                    if ({2'b00, widx} + 32'd1 >= (stride >> 2)) begin
                        if (off + 64'd4 + stride > {32'd0, map_end}) begin
                            done = 1'b1;
                            code = (best_bytes != 0) ? ST_FOUND : ST_NO_REGION;
                        end else begin
                            widx = '0;
                        end
                    end else begin
                        widx = widx + 30'd1;
                    end
                end
                default: walk_ph = PH_IDLE;
            endcase
            byte_off = byte_off + 32'd4;
        end
        if (done) begin
            res = status_only(code);
            if (code == ST_FOUND) begin
                res.base_addr = best_start;
                res.limit_addr = best_end;
                res.region_mib = {1'b0, best_bytes[63:20]} + {44'd0, |best_bytes[19:0]};
            end
            got = 1'b1;
            walk_ph = PH_DONE;
        end
    endtask

    // enter and leave at a falling edge
    task automatic send_word(input bmm_in_t item, input logic typed, input logic [2:0] st);
        int       gap;
        logic     got;
        bmm_out_t res;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        walked++;
        if (item.start_of_info)
            blocks_started++;
        scan_word(item.info_word, item.start_of_info, got, res);
        if (typed)
            pending_reports.push_back(status_only(st));
        else if (got)
            pending_reports.push_back(res);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_floor(input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        floor_addr = v;
    endtask

    function automatic void put(input logic [31:0] w);
        blk.push_back(w);
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(3))
            0:       return 64'd0;
            1:       return {32'd0, $urandom()};
            2:       return {$urandom(), $urandom()};
            default: return {32'd0, floor_addr} - 64'd32 + $urandom_range(0, 64);
        endcase
    endfunction

    function automatic logic [63:0] pick_len();
        case ($urandom_range(3))
            0:       return 64'd0;
            1:       return {32'd0, $urandom_range(1, 32'h0100_0000)};
            2:       return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // word 0 of blk carries the start flag
    task automatic build_block(input logic clean);
        int          n_other;
        int          n_ent;
        int          esz;
        int          step;
        int          msize;
        int          tsz;
        int          map_at;
        int          pick;
        int          cut;
        logic [31:0] ty;
        logic [31:0] total;
        logic [63:0] base;
        logic [63:0] len;
        blk.delete();
        cut = 0;
        put(32'd0);
        put($urandom());
        pick = $urandom_range(99);
        n_other = (pick >= 80) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        repeat (n_other) begin
            tsz = $urandom_range(8, 40);
            ty = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom();
            if (ty == TAG_TYPE_MMAP)
                ty = 32'd7;
            if (ty == TAG_TYPE_END && tsz == 8)
                tsz = 12;
            put(ty);
            put(tsz);
            repeat ((((tsz + 7) & ~7) - 8) / 4) put($urandom());
        end
        map_at = blk.size() * 4;
        if (pick < 70) begin
            esz = ($urandom_range(9) == 0) ? $urandom_range(0, 23) : $urandom_range(24, 40);
            step = (esz < 24) ? 24 : (esz & ~3);
            n_ent = $urandom_range(0, 4);
            msize = ($urandom_range(19) == 0) ? $urandom_range(0, 15)
                                              : 16 + n_ent * step + $urandom_range(0, 7);
            put(TAG_TYPE_MMAP);
            put(msize);
            put(esz);
            put($urandom());
            repeat (n_ent) begin
                base = pick_base();
                len = pick_len();
                put(base[31:0]);
                put(base[63:32]);
                put(len[31:0]);
                put(len[63:32]);
                put(($urandom_range(3) != 0) ? ENTRY_TYPE_RAM : $urandom());
                repeat (step / 4 - 5) put($urandom());
            end
            total = map_at + msize + $urandom_range(0, 16);
        end else begin
            if (pick < 80) begin
                put(TAG_TYPE_END);
                put(TAG_HDR_BYTES);
            end
            total = blk.size() * 4;
        end
        if (!clean) begin
            pick = $urandom_range(99);
            if (pick < 15)
                blk[$urandom_range(1, blk.size() - 1)] =
                    $urandom_range(1) ? $urandom() : $urandom_range(0, 48);
            else if (pick < 22)
                total = $urandom_range(1) ? $urandom() : $urandom_range(0, 64);
            else if (pick < 30)
                cut = $urandom_range(1, blk.size() - 1);
        end
        blk[0] = total;
        if (cut > 0)
            while (blk.size() > cut)
                void'(blk.pop_back());
        if (!clean && $urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) put($urandom());
    endtask

    task automatic send_block();
        bmm_in_t item;
        foreach (blk[i]) begin
            item.info_word = blk[i];
            item.start_of_info = (i == 0);
            send_word(item, 1'b0, ST_FOUND);
        end
    endtask

    initial begin
        bmm_in_t     item;
        int          phase_no;
        int          target;
        logic [31:0] floor_val;

        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b1, 1'b1, ST_BAD_INFO});
        stim_rows.push_back({32'hFFFF_FFFF, 1'b1, 1'b0, ST_FOUND});
        stim_rows.push_back({32'hFFFF_FFFF, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd16, 1'b1, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({TAG_TYPE_END, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({TAG_HDR_BYTES, 1'b0, 1'b1, ST_NO_MAP});
        stim_rows.push_back({32'd16, 1'b1, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd5, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd4, 1'b0, 1'b1, ST_BAD_INFO});
        stim_rows.push_back({32'd24, 1'b1, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({TAG_TYPE_MMAP, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd12, 1'b0, 1'b1, ST_BAD_MAP});
        stim_rows.push_back({32'd56, 1'b1, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({TAG_TYPE_MMAP, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd48, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd27, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'h0030_0001, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({ENTRY_TYPE_RAM, 1'b0, 1'b0, ST_FOUND});
        stim_rows.push_back({32'd0, 1'b0, 1'b0, ST_FOUND});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            item.info_word = stim_rows[i].word;
            item.start_of_info = stim_rows[i].sof;
            send_word(item, stim_rows[i].typed, stim_rows[i].status);
        end
        drain();

        walked = 0;
        phase_no = 0;
        while (walked < RANDOM_WORDS) begin
            case (phase_no % 5)
                0:       floor_val = 32'd0;
                1:       floor_val = 32'hFFFF_FFFF;
                2:       floor_val = MIN_START_RESET;
                3:       floor_val = $urandom();
                default: floor_val = $urandom_range(0, 32'h0400_0000);
            endcase
            case (phase_no % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 65; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 7;  stall_pct = 7;  end
            endcase
            set_floor(floor_val);
            target = walked + WORDS_PER_PHASE;
            while (walked < target) begin
                build_block(1'b0);
                send_block();
            end
            build_block(1'b1);
            send_block();
            drain();
            phase_no++;
        end

        $display("%0d blocks (%0d words sent) over %0d floor/idle phases, %0d reports",
                 blocks_started, walked, phase_no, reports);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
